FILE: rtl/core/tlr_pkg.sv
`timescale 1ns / 1ps

package tlr_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_TERM  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_TERM = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_EN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_HIGH = 3'd4;

    localparam logic [7:0] RST_FIRST_TERM  = 8'h0d;
    localparam logic [7:0] RST_SECOND_TERM = 8'h0a;
    localparam logic [7:0] RST_FILTER_LOW  = 8'h20;
    localparam logic [7:0] RST_FILTER_HIGH = 8'h7a;

    localparam logic [7:0] NO_DATA = 8'hff;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_ok;
        logic [7:0] line_length;
        logic       line_complete;
        logic       terminator_pending;
        logic       available;
    } result_t;

endpackage

FILE: rtl/core/tlr_in_if.sv
`timescale 1ns / 1ps

interface tlr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output data_byte, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input read_index,
                    output ready);
endinterface

FILE: rtl/core/tlr_out_if.sv
`timescale 1ns / 1ps

interface tlr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_ok;
    logic [7:0] line_length;
    logic       line_complete;
    logic       terminator_pending;
    logic       available;

    modport source (output valid, output read_data, output read_ok, output line_length,
                    output line_complete, output terminator_pending, output available,
                    input ready);
    modport sink   (input valid, input read_data, input read_ok, input line_length,
                    input line_complete, input terminator_pending, input available,
                    output ready);
endinterface

FILE: rtl/core/terminated_line_receiver.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_ch     in   valid/ready    opcode, data_byte, read_index
// out_ch    out  valid/ready    read_data, read_ok, line_length, line_complete,
//                               terminator_pending, available
// apb       in   psel/penable   five config registers at 4*i, pready always high
//
// One word per cycle sustained while the output does not stall; each word's result is
// registered in the result stage, beside the store's registered read, then in the output register.
// Count and flags update in the accept cycle, so a read right after a byte sees it.
// Reset clears count, flags and pipeline valids and loads the config defaults; the store needs no clearing.
// A stalled output holds the result stage; in_ch.ready drops only when both are full.

module terminated_line_receiver #(
    parameter int unsigned BUF_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tlr_in_if.sink                          in_ch,
    tlr_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tlr_pkg::*;

    localparam int unsigned CNT_W = $clog2(BUF_DEPTH);

    // configuration
    logic [7:0] first_term_reg;
    logic [7:0] second_term_reg;
    logic       filter_en_reg;
    logic [7:0] filter_low_reg;
    logic [7:0] filter_high_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_term_reg  <= RST_FIRST_TERM;
            second_term_reg <= RST_SECOND_TERM;
            filter_en_reg   <= 1'b0;
            filter_low_reg  <= RST_FILTER_LOW;
            filter_high_reg <= RST_FILTER_HIGH;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FIRST_TERM:  first_term_reg  <= pwdata[7:0];
                REG_SECOND_TERM: second_term_reg <= pwdata[7:0];
                REG_FILTER_EN:   filter_en_reg   <= pwdata[0];
                REG_FILTER_LOW:  filter_low_reg  <= pwdata[7:0];
                REG_FILTER_HIGH: filter_high_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FIRST_TERM:  prdata = {24'd0, first_term_reg};
            REG_SECOND_TERM: prdata = {24'd0, second_term_reg};
            REG_FILTER_EN:   prdata = {31'd0, filter_en_reg};
            REG_FILTER_LOW:  prdata = {24'd0, filter_low_reg};
            REG_FILTER_HIGH: prdata = {24'd0, filter_high_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // line state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             end_reg, end_next;
    logic             first_reg, first_next;

    // result stage (waits on the store read) and output register
    logic    s1_valid_reg;
    result_t s1_reg, s1_next;
    result_t s1_out;
    logic    out_valid_reg;
    result_t out_reg;

    logic             accept;
    logic             s1_adv;
    logic             out_free;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    logic [CNT_W:0]   count_inc;
    logic             rok;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign accept      = in_ch.valid && in_ch.ready;
    assign count_inc   = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        end_next   = end_reg;
        first_next = first_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        rok        = 1'b0;
        if (accept)
        begin
            unique case (in_ch.opcode)
                OP_BYTE:
                begin
                    if (end_reg)
                    begin
                        // line complete: byte ignored until cleared
                    end
                    else if (first_reg)
                    begin
                        if (in_ch.data_byte == second_term_reg)
                        begin
                            end_next = 1'b1;
                        end
                        else
                        begin
                            count_next = '0;
                            first_next = 1'b0;
                        end
                    end
                    else if (in_ch.data_byte == first_term_reg)
                    begin
                        first_next = 1'b1;
                    end
                    else if (filter_en_reg && (in_ch.data_byte < filter_low_reg ||
                                               in_ch.data_byte > filter_high_reg))
                    begin
                        // filtered out
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (count_inc == (CNT_W+1)'(BUF_DEPTH))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_inc[CNT_W-1:0];
                        end
                    end
                end
                OP_READ:
                begin
                    mem_re = 1'b1;
                    rok    = (end_reg || first_reg) && (in_ch.read_index < 8'(count_reg));
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    end_next   = 1'b0;
                    first_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        s1_next.read_data          = NO_DATA;
        s1_next.read_ok            = rok;
        s1_next.line_length        = 8'(count_next);
        s1_next.line_complete      = end_next;
        s1_next.terminator_pending = first_next;
        s1_next.available          = end_next || first_next;
    end

    tlr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg),
        .wdata (in_ch.data_byte),
        .re    (mem_re),
        .raddr (in_ch.read_index[CNT_W-1:0]),
        .rdata (mem_rdata)
    );

    // store data joins the status word on its way out
    always_comb
    begin
        s1_out           = s1_reg;
        s1_out.read_data = s1_reg.read_ok ? mem_rdata : NO_DATA;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            end_reg       <= 1'b0;
            first_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            end_reg   <= end_next;
            first_reg <= first_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_reg <= s1_out;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.read_data          = out_reg.read_data;
    assign out_ch.read_ok            = out_reg.read_ok;
    assign out_ch.line_length        = out_reg.line_length;
    assign out_ch.line_complete      = out_reg.line_complete;
    assign out_ch.terminator_pending = out_reg.terminator_pending;
    assign out_ch.available          = out_reg.available;

    a_count_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < (CNT_W+1)'(BUF_DEPTH))
        else $error("line count reached buffer depth");

    a_complete_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg |-> first_reg)
        else $error("line complete without first terminator");

    a_read_ok_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.read_ok) |-> out_reg.available)
        else $error("read returned data with no terminator seen");

    a_read_lands_in_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.opcode == OP_READ) |=> (s1_valid_reg && !s1_reg.line_complete ==
        !$past(end_reg)))
        else $error("read word lost on its way to the result stage");

endmodule

FILE: rtl/core/tlr_ram.sv
`timescale 1ns / 1ps

module tlr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tlr_pkg::*;

    localparam int unsigned LINE_DEPTH  = 256;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [7:0]  SEMICOLON   = 8'h3b;

    // Tracks the line state and queues one status word per accepted input word.
    class line_tracker;
        logic [7:0]  first_term;
        logic [7:0]  second_term;
        logic        filt_on;
        logic [7:0]  filt_low;
        logic [7:0]  filt_high;
        logic [7:0]  line_mem [LINE_DEPTH];
        int unsigned count;
        bit          complete;
        bit          pending;
        result_t     status_due [$];
        int unsigned errors;

        function new();
            first_term  = RST_FIRST_TERM;
            second_term = RST_SECOND_TERM;
            filt_on     = 1'b0;
            filt_low    = RST_FILTER_LOW;
            filt_high   = RST_FILTER_HIGH;
            errors      = 0;
            drop_line();
        endfunction

        function void drop_line();
            count    = 0;
            complete = 1'b0;
            pending  = 1'b0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [7:0] value);
            case (idx)
                REG_FIRST_TERM:  first_term  = value;
                REG_SECOND_TERM: second_term = value;
                REG_FILTER_EN:   filt_on     = value[0];
                REG_FILTER_LOW:  filt_low    = value;
                REG_FILTER_HIGH: filt_high   = value;
                default: ;
            endcase
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] b, logic [7:0] ix);
            result_t want;
            want.read_data = NO_DATA;
            want.read_ok   = 1'b0;
            case (op)
                OP_BYTE:
                begin
                    // a completed line swallows everything until a clear
                    if (!complete)
                    begin
                        if (pending)
                        begin
                            if (b == second_term)
                                complete = 1'b1;
                            else
                                drop_line();
                        end
                        else if (b == first_term)
                            pending = 1'b1;
                        else if (!(filt_on && (b < filt_low || b > filt_high)))
                        begin
                            line_mem[count[7:0]] = b;
                            count++;
                            if (count >= LINE_DEPTH)
                                drop_line();
                        end
                    end
                end
                OP_READ:
                begin
                    if ((complete || pending) && ix < count)
                    begin
                        want.read_data = line_mem[ix];
                        want.read_ok   = 1'b1;
                    end
                end
                OP_CLEAR: drop_line();
                default: ;
            endcase
            want.line_length        = count[7:0];
            want.line_complete      = complete;
            want.terminator_pending = pending;
            want.available          = complete || pending;
            status_due.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_status(result_t got);
            result_t want;
            if (status_due.size() == 0)
            begin
                report($sformatf("status word with nothing outstanding: %p", got));
                return;
            end
            want = status_due.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %02h, want %02h", got.read_data, want.read_data));
            if (got.read_ok !== want.read_ok)
                report($sformatf("read_ok %b, want %b", got.read_ok, want.read_ok));
            if (got.line_length !== want.line_length)
                report($sformatf("line_length %0d, want %0d",
                                 got.line_length, want.line_length));
            if (got.line_complete !== want.line_complete)
                report($sformatf("line_complete %b, want %b",
                                 got.line_complete, want.line_complete));
            if (got.terminator_pending !== want.terminator_pending)
                report($sformatf("terminator_pending %b, want %b",
                                 got.terminator_pending, want.terminator_pending));
            if (got.available !== want.available)
                report($sformatf("available %b, want %b", got.available, want.available));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit          idle_on;
    int unsigned words_sent;
    int unsigned stall_left;
    int unsigned cycles;
    line_tracker tracker;

    tlr_in_if  in_ch ();
    tlr_out_if out_ch ();

    terminated_line_receiver #(
        .BUF_DEPTH (LINE_DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    // result side: check every accepted word, stall in bursts
    always @(posedge clk)
    begin : rx
        result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.read_data          = out_ch.read_data;
            got.read_ok            = out_ch.read_ok;
            got.line_length        = out_ch.line_length;
            got.line_complete      = out_ch.line_complete;
            got.terminator_pending = out_ch.terminator_pending;
            got.available          = out_ch.available;
            tracker.check_status(got);
        end
        if (stall_left != 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // valid is left high on return so a following word goes out back to back
    task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [7:0] ix);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.data_byte  <= b;
        in_ch.read_index <= ix;
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.note_word(op, b, ix);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    function automatic logic [7:0] pick_data();
        if (tracker.filt_on && tracker.filt_low <= tracker.filt_high
            && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(tracker.filt_low, tracker.filt_high));
        return 8'($urandom_range(0, 255));
    endfunction

    // data only: the first terminator is kept out so the line stays open
    task automatic send_line(input int unsigned len);
        logic [7:0] b;
        repeat (len)
        begin
            b = pick_data();
            if (b == tracker.first_term)
                b = b ^ 8'h01;
            send_word(OP_BYTE, b, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_reads(input int unsigned n, input int unsigned span);
        logic [7:0] ix;
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
                ix = 8'($urandom_range(0, 255));
            else
                ix = 8'($urandom_range(0, span + 1));
            send_word(OP_READ, 8'($urandom_range(0, 255)), ix);
        end
    endtask

    task automatic configure(input int unsigned phase);
        logic [7:0] term_a;
        logic [7:0] term_b;
        logic       en;
        logic [7:0] lo;
        logic [7:0] hi;
        case (phase)
            0:
            begin
                term_a = SEMICOLON; term_b = RST_SECOND_TERM;
                en = 1'b1; lo = RST_FILTER_LOW; hi = RST_FILTER_HIGH;
            end
            1:
            begin
                term_a = 8'h00; term_b = 8'hff; en = 1'b1; lo = 8'h00; hi = 8'hff;
            end
            2:
            begin
                term_a = 8'hff; term_b = 8'h00; en = 1'b0; lo = 8'hff; hi = 8'h00;
            end
            3:
            begin
                // low above high: every data byte is dropped
                term_a = RST_FIRST_TERM; term_b = RST_SECOND_TERM;
                en = 1'b1; lo = RST_FILTER_HIGH; hi = RST_FILTER_LOW;
            end
            7:
            begin
                term_a = RST_FIRST_TERM; term_b = RST_SECOND_TERM;
                en = 1'b0; lo = RST_FILTER_LOW; hi = RST_FILTER_HIGH;
            end
            default:
            begin
                term_a = 8'($urandom_range(0, 255));
                term_b = 8'($urandom_range(0, 255));
                en     = 1'($urandom_range(0, 1));
                lo     = 8'($urandom_range(0, 200));
                hi     = 8'($urandom_range(lo, 255));
            end
        endcase
        write_reg(REG_FIRST_TERM, term_a);
        write_reg(REG_SECOND_TERM, term_b);
        write_reg(REG_FILTER_EN, {7'd0, en});
        write_reg(REG_FILTER_LOW, lo);
        write_reg(REG_FILTER_HIGH, hi);
    endtask

    task automatic run_random(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned len;
        logic [7:0]  wrong;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            kind = $urandom_range(0, 19);
            len  = $urandom_range(0, 20);
            if (kind < 14)
            begin
                if ($urandom_range(0, 1))
                    send_word(OP_CLEAR, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                send_line(len);
                send_word(OP_BYTE, tracker.first_term, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) == 0)
                    send_reads(1, len);
                send_word(OP_BYTE, tracker.second_term, 8'($urandom_range(0, 255)));
                send_reads($urandom_range(1, 4), len);
                if ($urandom_range(0, 2) == 0)
                    send_word(OP_BYTE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) != 0)
                    send_word(OP_CLEAR, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
            else if (kind < 17)
            begin
                send_line(len);
                send_word(OP_BYTE, tracker.first_term, 8'($urandom_range(0, 255)));
                wrong = 8'($urandom_range(0, 255));
                if (wrong == tracker.second_term)
                    wrong = ~wrong;
                send_word(OP_BYTE, wrong, 8'($urandom_range(0, 255)));
                send_reads(2, len);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        tracker    = new();
        idle_on    = 1'b1;
        words_sent = 0;
        stall_left = 0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_BYTE;
        in_ch.data_byte  <= 8'd0;
        in_ch.read_index <= 8'd0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: CR then LF, no filter
        send_word(OP_READ, 8'h00, 8'd0);
        send_word(OP_UNUSED, 8'hff, 8'hff);
        send_word(OP_CLEAR, 8'h00, 8'd0);
        send_word(OP_BYTE, 8'h00, 8'd0);
        send_word(OP_BYTE, 8'hff, 8'd0);
        send_word(OP_BYTE, 8'h41, 8'd0);
        send_word(OP_READ, 8'h00, 8'd0);
        send_word(OP_BYTE, RST_FIRST_TERM, 8'd0);
        send_word(OP_READ, 8'h00, 8'd0);
        send_word(OP_READ, 8'h00, 8'd2);
        send_word(OP_READ, 8'h00, 8'd3);
        send_word(OP_READ, 8'h00, 8'd255);
        send_word(OP_BYTE, RST_SECOND_TERM, 8'd0);
        send_word(OP_BYTE, 8'h78, 8'd0);
        send_word(OP_READ, 8'h00, 8'd1);
        send_word(OP_CLEAR, 8'h00, 8'd0);
        send_word(OP_BYTE, 8'h61, 8'd0);
        send_word(OP_BYTE, RST_FIRST_TERM, 8'd0);
        send_word(OP_BYTE, 8'h62, 8'd0);
        send_word(OP_BYTE, RST_FIRST_TERM, 8'd0);
        send_word(OP_BYTE, RST_SECOND_TERM, 8'd0);
        send_word(OP_READ, 8'h00, 8'd0);

        for (int unsigned phase = 0; phase < 8; phase++)
        begin
            if (phase == 7)
                idle_on = 1'b0;
            drain();
            configure(phase);
            if (phase == 0)
            begin
                // filter edges either side of 0x20..0x7a
                send_word(OP_BYTE, 8'h1f, 8'd0);
                send_word(OP_BYTE, 8'h20, 8'd0);
                send_word(OP_BYTE, 8'h7a, 8'd0);
                send_word(OP_BYTE, 8'h7b, 8'd0);
            end
            if (phase == 2)
            begin
                // longest line that fits, then one that fills the store and is lost
                send_word(OP_CLEAR, 8'h00, 8'd0);
                send_line(LINE_DEPTH - 1);
                send_word(OP_BYTE, tracker.first_term, 8'd0);
                send_reads(4, LINE_DEPTH - 2);
                send_word(OP_BYTE, tracker.second_term, 8'd0);
                send_word(OP_READ, 8'h00, 8'(LINE_DEPTH - 2));
                send_word(OP_CLEAR, 8'h00, 8'd0);
                send_line(LINE_DEPTH + $urandom_range(0, 4));
                send_word(OP_BYTE, tracker.first_term, 8'd0);
                send_reads(3, 6);
            end
            run_random(60);
        end
        drain();

        if (tracker.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
